// File: src/mf3_pkg.sv
`default_nettype none
package mf3_pkg;

   localparam int MAX_WIDTH    = 4096;
   localparam int CHANNEL_BITS = 8;
   localparam int ADDR_BITS    = $clog2(MAX_WIDTH);
   localparam int POS_BITS     = 12;
   localparam int DIM_BITS     = 13;
   localparam int WIN_TAPS     = 9;
   localparam int MEDIAN_RANK  = WIN_TAPS / 2;
   localparam int CNT_BITS     = $clog2(WIN_TAPS + 1);
   localparam int DATA_BITS    = 32;
   localparam int PADDR_BITS   = 3;
   localparam int COUNT_LIMIT  = 4096;
   localparam int WIDTH_LIMIT  = (MAX_WIDTH < COUNT_LIMIT) ? MAX_WIDTH : COUNT_LIMIT;
   localparam logic [DIM_BITS-1:0] WIDTH_RESET  = DIM_BITS'(640);
   localparam logic [DIM_BITS-1:0] HEIGHT_RESET = DIM_BITS'(480);

   typedef enum logic {
      REG_IMAGE_WIDTH  = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } reg_index_type;

   typedef logic [CHANNEL_BITS-1:0] chan_type;
   typedef chan_type [2:0] pix_type;
   typedef pix_type [2:0] column_type;
   typedef column_type [2:0] window_type;
   typedef chan_type [WIN_TAPS-1:0] taps_type;

   typedef struct packed {
      logic [POS_BITS-1:0] row;
      logic [POS_BITS-1:0] col;
      logic                row_a;
      logic                row_b;
      logic                r_ge2;
      logic                col_a;
      logic                col_b;
      logic                c_ge2;
   } job_type;

endpackage
`default_nettype wire

// File: src/mf3_csr.sv
`default_nettype none
module mf3_csr
   import mf3_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [PADDR_BITS-1:0] paddr,
   input  wire logic [DATA_BITS-1:0]  pwdata,
   output logic      [DATA_BITS-1:0]  prdata,
   output logic                       pready,
   output logic      [DIM_BITS-1:0]   image_width,
   output logic      [DIM_BITS-1:0]   image_height
);

   logic [DIM_BITS-1:0] width_ff, width_in;
   logic [DIM_BITS-1:0] height_ff, height_in;
   reg_index_type       index;
   logic                wr;

   assign index  = reg_index_type'(paddr[2]);
   assign wr     = psel & penable & pwrite;
   assign pready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (wr) begin
         unique case (index)
            REG_IMAGE_WIDTH:  width_in  = pwdata[DIM_BITS-1:0];
            REG_IMAGE_HEIGHT: height_in = pwdata[DIM_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_IMAGE_WIDTH:  prdata = DATA_BITS'(width_ff);
         REG_IMAGE_HEIGHT: prdata = DATA_BITS'(height_ff);
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   assign image_width  = width_ff;
   assign image_height = height_ff;

endmodule
`default_nettype wire

// File: src/mf3_window.sv
`default_nettype none
module mf3_window
   import mf3_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire chan_type            red_in,
   input  wire chan_type            green_in,
   input  wire chan_type            blue_in,
   input  wire logic [DIM_BITS-1:0] image_width,
   input  wire logic [DIM_BITS-1:0] image_height,
   input  wire logic                take,
   output logic                     s1_valid,
   output job_type                  job,
   output window_type               window
);

   logic [POS_BITS-1:0]  row_ff, row_in, col_ff, col_in;
   logic                 s1_valid_ff, s1_valid_in;
   pix_type              px_ff, up_rd_ff, lo_rd_ff, fwd_up_ff, fwd_lo_ff;
   logic                 hit_ff;
   logic [ADDR_BITS-1:0] idx_ff, idx;
   job_type              job_ff, job_in;
   window_type           window_ff;
   pix_type              upper_mem [MAX_WIDTH];
   pix_type              lower_mem [MAX_WIDTH];
   pix_type              up_eff, lo_eff, px_in;
   logic [DIM_BITS-1:0]  w, h;
   logic                 accept, commit, lastr, lastc;

   assign px_in = {blue_in, green_in, red_in};
   assign idx   = ADDR_BITS'(col_ff);

   always_comb begin
      if (image_width == '0)
         w = DIM_BITS'(1);
      else if (image_width > DIM_BITS'(WIDTH_LIMIT))
         w = DIM_BITS'(WIDTH_LIMIT);
      else
         w = image_width;
      if (image_height == '0)
         h = DIM_BITS'(1);
      else if (image_height > DIM_BITS'(COUNT_LIMIT))
         h = DIM_BITS'(COUNT_LIMIT);
      else
         h = image_height;
   end

   assign commit    = s1_valid_ff & take;
   assign req_stall = s1_valid_ff & ~take;
   assign accept    = req_valid & ~req_stall;
   assign lastr     = ({1'b0, row_ff} + DIM_BITS'(1)) >= h;
   assign lastc     = ({1'b0, col_ff} + DIM_BITS'(1)) >= w;
   assign up_eff    = hit_ff ? fwd_up_ff : up_rd_ff;
   assign lo_eff    = hit_ff ? fwd_lo_ff : lo_rd_ff;

   always_comb begin
      job_in.row   = row_ff;
      job_in.col   = col_ff;
      job_in.row_a = row_ff != '0;
      job_in.row_b = lastr;
      job_in.r_ge2 = row_ff >= POS_BITS'(2);
      job_in.col_a = col_ff != '0;
      job_in.col_b = lastc;
      job_in.c_ge2 = col_ff >= POS_BITS'(2);
   end

   always_comb begin
      row_in      = row_ff;
      col_in      = col_ff;
      s1_valid_in = s1_valid_ff & ~commit;
      if (accept) begin
         s1_valid_in = 1'b1;
         if (lastc) begin
            col_in = '0;
            row_in = lastr ? '0 : row_ff + POS_BITS'(1);
         end else begin
            col_in = col_ff + POS_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff      <= '0;
         col_ff      <= '0;
         s1_valid_ff <= 1'b0;
         window_ff   <= '0;
      end else begin
         row_ff      <= row_in;
         col_ff      <= col_in;
         s1_valid_ff <= s1_valid_in;
         if (commit)
            window_ff <= {window_ff[1], window_ff[0], {px_ff, lo_eff, up_eff}};
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         px_ff     <= px_in;
         idx_ff    <= idx;
         job_ff    <= job_in;
         hit_ff    <= commit && (idx_ff == idx);
         fwd_up_ff <= lo_eff;
         fwd_lo_ff <= px_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (commit)
         upper_mem[idx_ff] <= lo_eff;
      if (accept)
         up_rd_ff <= upper_mem[idx];
   end

   always_ff @(posedge clock) begin
      if (commit)
         lower_mem[idx_ff] <= px_ff;
      if (accept)
         lo_rd_ff <= lower_mem[idx];
   end

   assign s1_valid = s1_valid_ff;
   assign job      = job_ff;
   assign window   = window_ff;

endmodule
`default_nettype wire

// File: src/mf3_median.sv
`default_nettype none
module mf3_median
   import mf3_pkg::*;
(
   input  wire taps_type taps,
   output chan_type      median
);

   logic [CNT_BITS-1:0] n_lt [WIN_TAPS];
   logic [CNT_BITS-1:0] n_le [WIN_TAPS];

   always_comb begin
      for (int i = 0; i < WIN_TAPS; i++) begin
         n_lt[i] = '0;
         n_le[i] = '0;
         for (int j = 0; j < WIN_TAPS; j++) begin
            n_lt[i] = n_lt[i] + CNT_BITS'(taps[j] < taps[i]);
            n_le[i] = n_le[i] + CNT_BITS'(taps[j] <= taps[i]);
         end
      end
   end

   // any rank match carries the same value
   always_comb begin
      median = '0;
      for (int i = 0; i < WIN_TAPS; i++) begin
         if (n_lt[i] <= CNT_BITS'(MEDIAN_RANK) && n_le[i] >= CNT_BITS'(MEDIAN_RANK + 1))
            median = median | taps[i];
      end
   end

endmodule
`default_nettype wire

// File: src/mf3_out.sv
`default_nettype none
module mf3_out
   import mf3_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       s1_valid,
   input  wire job_type    job_in,
   input  wire window_type window,
   output logic            take,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output chan_type        red_out,
   output chan_type        green_out,
   output chan_type        blue_out,
   output logic [POS_BITS-1:0] out_row,
   output logic [POS_BITS-1:0] out_col,
   output logic            run_last,
   output logic            frame_end
);

   job_type             job_ff;
   logic                busy_ff, busy_in;
   logic                rb_ff, rb_in, cb_ff, cb_in;
   logic                valid_ff, valid_in;
   pix_type             pix_ff;
   logic [POS_BITS-1:0] row_ff, col_ff;
   logic                last_ff, fend_ff;
   logic [1:0]          rsel [3];
   logic [1:0]          csel [3];
   taps_type            taps [3];
   pix_type             med;
   logic                issue, more_col, more_row, last, load;

   assign issue    = busy_ff & (~valid_ff | ~rsp_stall);
   assign more_col = ~cb_ff & job_ff.col_b;
   assign more_row = ~rb_ff & job_ff.row_b;
   assign last     = ~more_col & ~more_row;
   assign take     = ~busy_ff | (issue & last);
   assign load     = s1_valid & take;

   always_comb begin
      if (!rb_ff) begin
         rsel[0] = job_ff.r_ge2 ? 2'd0 : 2'd1;
         rsel[1] = 2'd1;
         rsel[2] = 2'd2;
      end else begin
         rsel[0] = job_ff.row_a ? 2'd1 : 2'd2;
         rsel[1] = 2'd2;
         rsel[2] = 2'd2;
      end
      if (!cb_ff) begin
         csel[0] = job_ff.c_ge2 ? 2'd2 : 2'd1;
         csel[1] = 2'd1;
         csel[2] = 2'd0;
      end else begin
         csel[0] = job_ff.col_a ? 2'd1 : 2'd0;
         csel[1] = 2'd0;
         csel[2] = 2'd0;
      end
   end

   always_comb begin
      for (int ch = 0; ch < 3; ch++)
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
               taps[ch][i*3+j] = window[csel[j]][rsel[i]][ch];
   end

   for (genvar g = 0; g < 3; g++) begin : g_med
      mf3_median u_median (
         .taps   (taps[g]),
         .median (med[g])
      );
   end

   always_comb begin
      busy_in  = busy_ff;
      rb_in    = rb_ff;
      cb_in    = cb_ff;
      valid_in = valid_ff & rsp_stall;
      if (issue) begin
         valid_in = 1'b1;
         if (more_col) begin
            cb_in = 1'b1;
         end else if (more_row) begin
            rb_in = 1'b1;
            cb_in = ~job_ff.col_a;
         end else begin
            busy_in = 1'b0;
         end
      end
      if (load) begin
         busy_in = (job_in.row_a | job_in.row_b) & (job_in.col_a | job_in.col_b);
         rb_in   = ~job_in.row_a;
         cb_in   = ~job_in.col_a;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rb_ff <= rb_in;
      cb_ff <= cb_in;
      if (load)
         job_ff <= job_in;
      if (issue) begin
         pix_ff  <= med;
         row_ff  <= rb_ff ? job_ff.row : job_ff.row - POS_BITS'(1);
         col_ff  <= cb_ff ? job_ff.col : job_ff.col - POS_BITS'(1);
         last_ff <= last;
         fend_ff <= rb_ff & cb_ff;
      end
   end

   assign rsp_valid = valid_ff;
   assign red_out   = pix_ff[0];
   assign green_out = pix_ff[1];
   assign blue_out  = pix_ff[2];
   assign out_row   = row_ff;
   assign out_col   = col_ff;
   assign run_last  = last_ff;
   assign frame_end = fend_ff;

endmodule
`default_nettype wire

// File: src/median_filter_3x3_rgb_top.sv
// path: an accepted word goes through the stage-one, window and output registers
// throughput: one input word per cycle while req_stall is low; an input that
// releases n results (up to four, at row and frame ends) holds the input stalled
// until its last result issues, one result per cycle while rsp_stall is low
// reset: synchronous, active high; clears counters, window and handshake state,
// line stores are not cleared
`default_nettype none
module median_filter_3x3_rgb_top
   import mf3_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire chan_type              req_red_in,
   input  wire chan_type              req_green_in,
   input  wire chan_type              req_blue_in,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output chan_type                   rsp_red_out,
   output chan_type                   rsp_green_out,
   output chan_type                   rsp_blue_out,
   output logic      [POS_BITS-1:0]   rsp_out_row,
   output logic      [POS_BITS-1:0]   rsp_out_col,
   output logic                       rsp_run_last,
   output logic                       rsp_frame_end,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [PADDR_BITS-1:0] paddr,
   input  wire logic [DATA_BITS-1:0]  pwdata,
   output logic      [DATA_BITS-1:0]  prdata,
   output logic                       pready
);

   logic [DIM_BITS-1:0] image_width, image_height;
   logic                take, s1_valid;
   job_type             job;
   window_type          window;

   mf3_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .image_width  (image_width),
      .image_height (image_height)
   );

   mf3_window u_window (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .red_in       (req_red_in),
      .green_in     (req_green_in),
      .blue_in      (req_blue_in),
      .image_width  (image_width),
      .image_height (image_height),
      .take         (take),
      .s1_valid     (s1_valid),
      .job          (job),
      .window       (window)
   );

   mf3_out u_out (
      .clock     (clock),
      .reset     (reset),
      .s1_valid  (s1_valid),
      .job_in    (job),
      .window    (window),
      .take      (take),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .red_out   (rsp_red_out),
      .green_out (rsp_green_out),
      .blue_out  (rsp_blue_out),
      .out_row   (rsp_out_row),
      .out_col   (rsp_out_col),
      .run_last  (rsp_run_last),
      .frame_end (rsp_frame_end)
   );

endmodule
`default_nettype wire

// File: src/mf3_checker.sv
`default_nettype none
module mf3_checker
   import mf3_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                rsp_valid,
   input wire logic                rsp_stall,
   input wire chan_type            rsp_red_out,
   input wire logic [POS_BITS-1:0] rsp_out_row,
   input wire logic [POS_BITS-1:0] rsp_out_col,
   input wire logic                rsp_run_last,
   input wire logic                rsp_frame_end,
   input wire logic                pready
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_red_out) && $stable(rsp_out_col))
      else $error("stalled result word changed");

   a_fend_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_run_last)
      else $error("frame end without run last");

   a_next_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_run_last |=> !rsp_valid || rsp_out_row != $past(rsp_out_row) || rsp_out_col == $past(rsp_out_col) + POS_BITS'(1))
      else $error("results of one word out of column order");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_ready: assert property (@(posedge clock) disable iff (reset)
      pready)
      else $error("register port not ready");

endmodule

bind median_filter_3x3_rgb_top mf3_checker u_mf3_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_red_out   (rsp_red_out),
   .rsp_out_row   (rsp_out_row),
   .rsp_out_col   (rsp_out_col),
   .rsp_run_last  (rsp_run_last),
   .rsp_frame_end (rsp_frame_end),
   .pready        (pready)
);
`default_nettype wire
